### rtl/core/saa_pkg.sv
// Shared types and constants of the shelf atlas allocator.
package saa_pkg;

   localparam int DEF_MAX_SHELVES  = 64;
   localparam int DEF_MAX_SIDE     = 4096;
   localparam int DEF_INITIAL_SIDE = 128;

   localparam int SIDE_W = 15;
   localparam int IDX_W  = 10;
   localparam int CNT_W  = IDX_W + 1;
   localparam int RECT_W = 13;
   localparam logic [SIDE_W-1:0] FIRST_FREE_ROW = SIDE_W'(3);
   localparam logic [16:0] RECIP_TEN = 17'd6554;

   typedef struct packed {
      logic              valid;
      logic              found;
      logic [IDX_W-1:0]  idx;
      logic [SIDE_W-1:0] best_h;
      logic [SIDE_W-1:0] best_top;
      logic [SIDE_W-1:0] best_fill;
   } scan_rec_type;

   typedef struct packed {
      logic              en;
      logic              new_shelf;
      logic [IDX_W-1:0]  idx;
      logic [SIDE_W-1:0] top;
      logic [SIDE_W-1:0] height;
      logic [SIDE_W-1:0] fill;
   } shelf_upd_type;

endpackage

### rtl/core/saa_cell.sv
// One shelf cell of the scan chain: holds a shelf and refines the best candidate.
module saa_cell import saa_pkg::*; #(
   parameter int CELL_IDX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [CNT_W-1:0]    shelf_count,
   input  logic [SIDE_W-1:0]   side,
   input  logic [RECT_W-1:0]   rect_w,
   input  logic [RECT_W-1:0]   rect_h,
   input  shelf_upd_type       upd,
   input  scan_rec_type        scan_in,
   output scan_rec_type        scan_out
);

   logic [SIDE_W-1:0] top_ff, height_ff, fill_ff;
   scan_rec_type      scan_ff, scan_in_rec;
   logic              active, hit, take;
   logic [17:0]       h10, sh7;

   assign active = shelf_count > CNT_W'(CELL_IDX);
   assign h10 = 18'(rect_h) * 18'd10;
   assign sh7 = 18'(height_ff) * 18'd7;
   assign hit = active && (h10 >= sh7) && (SIDE_W'(rect_h) <= height_ff) &&
                (fill_ff <= side) && (16'(rect_w) <= 16'(side - fill_ff));
   assign take = hit && (!scan_in.found || rect_h == '0 || height_ff <= scan_in.best_h);

   always_comb begin
      scan_in_rec = scan_in;
      if (take) begin
         scan_in_rec.found     = 1'b1;
         scan_in_rec.idx       = IDX_W'(CELL_IDX);
         scan_in_rec.best_h    = height_ff;
         scan_in_rec.best_top  = top_ff;
         scan_in_rec.best_fill = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff.valid <= 1'b0;
      end else begin
         scan_ff.valid <= scan_in.valid;
      end
      scan_ff.found     <= scan_in_rec.found;
      scan_ff.idx       <= scan_in_rec.idx;
      scan_ff.best_h    <= scan_in_rec.best_h;
      scan_ff.best_top  <= scan_in_rec.best_top;
      scan_ff.best_fill <= scan_in_rec.best_fill;
      if (upd.en && upd.idx == IDX_W'(CELL_IDX)) begin
         fill_ff <= upd.fill;
         if (upd.new_shelf) begin
            top_ff    <= upd.top;
            height_ff <= upd.height;
         end
      end
   end

   assign scan_out = scan_ff;

endmodule

### rtl/core/shelf_atlas_allocator.sv
// Shelf packing allocator for a square texture atlas, built as a chain of shelf cells.
// The strobe rises once the scan record has walked through every cell, when a shelf fits or
// the table is full; a new shelf or a side failure passes through the grow state first, which
// doubles the side until the row fits. A new transaction is taken only once the last is through,
// as busy falls with the strobe. The receiver cannot stall the result.
// Synchronous reset clears the shelf count, sets the first free row to 3 and the side.
module shelf_atlas_allocator import saa_pkg::*; #(
   parameter int MAX_SHELVES  = DEF_MAX_SHELVES,
   parameter int MAX_SIDE     = DEF_MAX_SIDE,
   parameter int INITIAL_SIDE = DEF_INITIAL_SIDE
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [12:0]       req_rect_width,
   input  logic [12:0]       req_rect_height,
   output logic              rsp_valid,
   output logic [11:0]       rsp_place_left,
   output logic [11:0]       rsp_place_top,
   output logic [12:0]       rsp_atlas_side,
   output logic              rsp_atlas_grew,
   output logic              rsp_alloc_failed
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_GROW = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [RECT_W-1:0] w_ff, h_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [SIDE_W-1:0] nfr_ff, side_ff, side_tmp_ff, side_tmp_in;
   logic [SIDE_W-1:0] row_h;
   logic [29:0]       h_scaled;
   logic [15:0]       row_end;
   logic [15:0]       side_dbl;
   logic              need_grow;
   logic              go_ff;
   shelf_upd_type     upd;
   scan_rec_type      inject;
   scan_rec_type      link [MAX_SHELVES+1];
   logic              rsp_in, grew_in, fail_in;
   logic [SIDE_W-1:0] left_in, top_in;

   assign h_scaled  = 30'(h_ff) * 30'(RECIP_TEN);
   assign row_h     = SIDE_W'(h_ff) + SIDE_W'(h_scaled[29:16]);
   assign row_end   = 16'(nfr_ff) + 16'(row_h);
   assign side_dbl  = {side_tmp_ff, 1'b0};
   assign need_grow = (row_end >= 16'(side_tmp_ff)) || (16'(w_ff) >= 16'(side_tmp_ff));

   always_comb begin
      inject       = '0;
      inject.valid = go_ff;
   end

   assign link[0] = inject;

   for (genvar g = 0; g < MAX_SHELVES; g++) begin : g_cell
      saa_cell #(.CELL_IDX(g)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .shelf_count (count_ff),
         .side        (side_ff),
         .rect_w      (w_ff),
         .rect_h      (h_ff),
         .upd         (upd),
         .scan_in     (link[g]),
         .scan_out    (link[g+1])
      );
   end

   always_comb begin
      state_in    = state_ff;
      side_tmp_in = side_tmp_ff;
      upd         = '0;
      rsp_in      = 1'b0;
      grew_in     = 1'b0;
      fail_in     = 1'b0;
      left_in     = '0;
      top_in      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            side_tmp_in = side_ff;
            if (link[MAX_SHELVES].valid) begin
               if (link[MAX_SHELVES].found) begin
                  upd.en   = 1'b1;
                  upd.idx  = link[MAX_SHELVES].idx;
                  upd.fill = link[MAX_SHELVES].best_fill + SIDE_W'(w_ff);
                  rsp_in   = 1'b1;
                  left_in  = link[MAX_SHELVES].best_fill;
                  top_in   = link[MAX_SHELVES].best_top;
                  state_in = ST_IDLE;
               end else if (count_ff >= CNT_W'(MAX_SHELVES)) begin
                  rsp_in   = 1'b1;
                  fail_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_GROW;
               end
            end
         end
         ST_GROW: begin
            if (need_grow) begin
               if (32'(side_dbl) > 32'(MAX_SIDE)) begin
                  rsp_in   = 1'b1;
                  fail_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  side_tmp_in = side_dbl[SIDE_W-1:0];
               end
            end else begin
               upd.en        = 1'b1;
               upd.new_shelf = 1'b1;
               upd.idx       = count_ff[IDX_W-1:0];
               upd.top       = nfr_ff;
               upd.height    = row_h;
               upd.fill      = SIDE_W'(w_ff);
               rsp_in        = 1'b1;
               grew_in       = side_tmp_ff != side_ff;
               top_in        = nfr_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         nfr_ff    <= FIRST_FREE_ROW;
         side_ff   <= SIDE_W'(INITIAL_SIDE);
         rsp_valid <= 1'b0;
         go_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rsp_valid <= rsp_in;
         go_ff     <= start && !busy;
         if (upd.en && upd.new_shelf) begin
            count_ff <= count_ff + CNT_W'(1);
            nfr_ff   <= row_end[SIDE_W-1:0];
            side_ff  <= side_tmp_ff;
         end
      end
      side_tmp_ff <= side_tmp_in;
      if (start && !busy) begin
         w_ff <= req_rect_width;
         h_ff <= req_rect_height;
      end
      rsp_place_left   <= left_in[11:0];
      rsp_place_top    <= top_in[11:0];
      rsp_atlas_side   <= (upd.en && upd.new_shelf) ? side_tmp_ff[12:0] : side_ff[12:0];
      rsp_atlas_grew   <= grew_in;
      rsp_alloc_failed <= fail_in;
   end

   assign busy = state_ff != ST_IDLE;

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("Result strobe without a transaction in flight.");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Accepted transaction did not raise busy.");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SHELVES))
      else $error("Shelf count exceeds the table size.");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_alloc_failed) |-> (!rsp_atlas_grew && $stable(count_ff)))
      else $error("Failed transaction changed the atlas.");

endmodule
